@@ hdl/bis_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_pkg
// Shared sizes, types and codes of the bilinear image scaler.
// ----------------------------------------------------------------------------
package bis_pkg;

   // Store geometry and sample width.
   localparam int MAX_WIDTH    = 256;
   localparam int MAX_HEIGHT   = 256;
   localparam int MAX_CHANNELS = 4;
   localparam int SAMPLE_BITS  = 16;

   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;
   localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
   localparam int X_BITS      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int Y_BITS      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

   // Fixed field widths of the ports and the datapath.
   localparam int POS_BITS    = 12;
   localparam int CHAN_BITS   = 2;
   localparam int FIELD_BITS  = 16;
   localparam int SIZE_BITS   = 9;
   localparam int COUNT_BITS  = 3;
   localparam int SCALE_BITS  = 20;
   localparam int CSR_BITS    = 20;
   localparam int FRAC_BITS   = 16;
   localparam int WEIGHT_BITS = FRAC_BITS + 1;
   localparam int LIMIT_BITS  = 13;
   localparam int ACC_BITS    = 48;

   // Unit weight in Q1.16 terms.
   localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = WEIGHT_BITS'(1 << FRAC_BITS);

   // Register reset values.
   localparam logic [SIZE_BITS-1:0]  RESET_WIDTH    = 9'd256;
   localparam logic [SIZE_BITS-1:0]  RESET_HEIGHT   = 9'd256;
   localparam logic [COUNT_BITS-1:0] RESET_CHANNELS = 3'd3;
   localparam logic [SCALE_BITS-1:0] RESET_SCALE    = 20'd65536;

   typedef logic [ADDR_BITS-1:0] addr_type;
   typedef logic [X_BITS-1:0]    xcoord_type;
   typedef logic [Y_BITS-1:0]    ycoord_type;
   typedef logic [CHAN_BITS-1:0] chan_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_SRC_WIDTH     = 2'd0,
      CSR_SRC_HEIGHT    = 2'd1,
      CSR_CHANNEL_COUNT = 2'd2,
      CSR_INV_SCALE     = 2'd3
   } csr_index_type;

   // Request sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAP_X,
      ST_MAP_Y,
      ST_CLAMP_Y,
      ST_FETCH,
      ST_DRAIN
   } state_type;

   // Linear store address of one sample: pixel-interleaved channels, row major.
   function automatic addr_type store_addr(input xcoord_type x, input ycoord_type y,
                                           input chan_type c);
      store_addr = addr_type'((ADDR_BITS'(y) * ADDR_BITS'(MAX_WIDTH) + ADDR_BITS'(x))
                              * ADDR_BITS'(MAX_CHANNELS) + ADDR_BITS'(c));
   endfunction

endpackage

@@ hdl/bilinear_image_scaler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_image_scaler
// Stores a source image and answers bilinear interpolated sample requests.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                   Payload
//  -------   -------------------------   -----------------------------------------
//  request   start, busy                 req_kind, req_pos_x, req_pos_y, req_chan,
//                                        req_sample_in
//  response  rsp_valid (one-cycle pulse) rsp_sample_out, rsp_status
//  csr       csr_write_enable            csr_index, csr_data
//
//  A write transaction is taken while idle; busy stays low after it.
//  A request with a channel out of range leaves busy low; its response follows
//  in the next cycle.
//  An interpolated request holds busy, and no new transaction is accepted
//  until busy drops: the map-x and map-y multiplies and the clamp-y step map
//  the position, the fetch state reads the four neighbors through the single
//  store port, and the drain state empties the multiply-accumulate pipeline.
//  The response pulses in the cycle busy drops.
//  Reset is synchronous, clears control state and loads register reset values;
//  the sample store is not cleared. The response cannot be stalled.
// ----------------------------------------------------------------------------
module bilinear_image_scaler (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_kind,
   input  logic [bis_pkg::POS_BITS-1:0]     req_pos_x,
   input  logic [bis_pkg::POS_BITS-1:0]     req_pos_y,
   input  logic [bis_pkg::CHAN_BITS-1:0]    req_chan,
   input  logic [bis_pkg::FIELD_BITS-1:0]   req_sample_in,
   output logic                             rsp_valid,
   output logic [bis_pkg::FIELD_BITS-1:0]   rsp_sample_out,
   output logic                             rsp_status,
   input  logic                             csr_write_enable,
   input  logic [1:0]                       csr_index,
   input  logic [bis_pkg::CSR_BITS-1:0]     csr_data
);

   // Configuration registers.
   logic [bis_pkg::SIZE_BITS-1:0]  src_width_ff;
   logic [bis_pkg::SIZE_BITS-1:0]  src_height_ff;
   logic [bis_pkg::COUNT_BITS-1:0] channel_count_ff;
   logic [bis_pkg::SCALE_BITS-1:0] inv_scale_ff;

   // Control state.
   bis_pkg::state_type state_ff, state_in;
   logic [1:0]         cnt_ff, cnt_in;
   logic               v1_ff, v1_in;
   logic               v2_ff;
   logic               emit;
   logic               mem_re;
   logic               mem_we;

   // Request registers and datapath.
   logic [bis_pkg::POS_BITS-1:0]    px_ff, py_ff;
   bis_pkg::chan_type               chan_ff;
   logic [31:0]                     mul_ff, mul_in;
   logic [bis_pkg::FRAC_BITS-1:0]   fx_ff, fy_ff;
   bis_pkg::xcoord_type             x0_ff, x1_ff, x0_in, x1_in;
   bis_pkg::ycoord_type             y0_ff, y1_ff, y0_in, y1_in;
   logic [2*bis_pkg::WEIGHT_BITS-1:0] weight_ff, weight_in;
   logic [bis_pkg::ACC_BITS-1:0]    prod_ff, prod_in;
   logic [bis_pkg::ACC_BITS-1:0]    acc_ff, acc_in;

   // Response registers.
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [bis_pkg::FIELD_BITS-1:0]  rsp_sample_ff, rsp_sample_in;
   logic                            rsp_status_ff, rsp_status_in;

   // Sample store.
   logic [bis_pkg::SAMPLE_BITS-1:0] store_mem [bis_pkg::STORE_DEPTH];
   logic [bis_pkg::SAMPLE_BITS-1:0] mem_rdata_ff;
   bis_pkg::addr_type               mem_addr;
   bis_pkg::addr_type               fetch_addr;
   bis_pkg::addr_type               write_addr;

   // Decode helpers.
   logic                                accept;
   logic                                chan_ok;
   logic                                bad_req;
   logic [bis_pkg::COUNT_BITS-1:0]      nch;
   logic [bis_pkg::LIMIT_BITS-1:0]      lim_x, lim_y, w13, h13;
   bis_pkg::xcoord_type                 last_x;
   bis_pkg::ycoord_type                 last_y;
   logic [15:0]                         ipart;
   logic [16:0]                         ipart_p1;
   logic [bis_pkg::WEIGHT_BITS-1:0]     wx, wy;
   logic [2*bis_pkg::WEIGHT_BITS-1:0]   wprod;
   logic [bis_pkg::FIELD_BITS-1:0]      rd_sample;
   logic [bis_pkg::ACC_BITS:0]          pfull;
   logic [bis_pkg::ACC_BITS:0]          rounded;

   // The handshake and channel range check.
   assign busy    = (state_ff != bis_pkg::ST_IDLE);
   assign accept  = start && !busy;
   assign nch     = (channel_count_ff > bis_pkg::COUNT_BITS'(bis_pkg::MAX_CHANNELS)) ?
                    bis_pkg::COUNT_BITS'(bis_pkg::MAX_CHANNELS) : channel_count_ff;
   assign chan_ok = (bis_pkg::COUNT_BITS'(req_chan) < nch);
   assign bad_req = accept && req_kind && !chan_ok;

   // A source write lands in the store at the accepting edge.
   assign mem_we = accept && !req_kind && chan_ok
                   && (bis_pkg::LIMIT_BITS'(req_pos_x) < bis_pkg::LIMIT_BITS'(bis_pkg::MAX_WIDTH))
                   && (bis_pkg::LIMIT_BITS'(req_pos_y) < bis_pkg::LIMIT_BITS'(bis_pkg::MAX_HEIGHT));

   // Effective last column and row of the source image.
   always_comb begin
      w13 = bis_pkg::LIMIT_BITS'(src_width_ff);
      h13 = bis_pkg::LIMIT_BITS'(src_height_ff);
      if (w13 == '0) begin
         lim_x = bis_pkg::LIMIT_BITS'(1);
      end else if (w13 > bis_pkg::LIMIT_BITS'(bis_pkg::MAX_WIDTH)) begin
         lim_x = bis_pkg::LIMIT_BITS'(bis_pkg::MAX_WIDTH);
      end else begin
         lim_x = w13;
      end
      if (h13 == '0) begin
         lim_y = bis_pkg::LIMIT_BITS'(1);
      end else if (h13 > bis_pkg::LIMIT_BITS'(bis_pkg::MAX_HEIGHT)) begin
         lim_y = bis_pkg::LIMIT_BITS'(bis_pkg::MAX_HEIGHT);
      end else begin
         lim_y = h13;
      end
      last_x = bis_pkg::X_BITS'(lim_x - bis_pkg::LIMIT_BITS'(1));
      last_y = bis_pkg::Y_BITS'(lim_y - bis_pkg::LIMIT_BITS'(1));
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff     <= bis_pkg::RESET_WIDTH;
         src_height_ff    <= bis_pkg::RESET_HEIGHT;
         channel_count_ff <= bis_pkg::RESET_CHANNELS;
         inv_scale_ff     <= bis_pkg::RESET_SCALE;
      end else if (csr_write_enable) begin
         case (csr_index)
            bis_pkg::CSR_SRC_WIDTH: begin
               src_width_ff <= csr_data[bis_pkg::SIZE_BITS-1:0];
            end
            bis_pkg::CSR_SRC_HEIGHT: begin
               src_height_ff <= csr_data[bis_pkg::SIZE_BITS-1:0];
            end
            bis_pkg::CSR_CHANNEL_COUNT: begin
               channel_count_ff <= csr_data[bis_pkg::COUNT_BITS-1:0];
            end
            bis_pkg::CSR_INV_SCALE: begin
               inv_scale_ff <= csr_data[bis_pkg::SCALE_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Sequencer: map x, map y, clamp y, four reads, then drain the pipeline.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      mem_re   = 1'b0;
      v1_in    = 1'b0;
      emit     = 1'b0;
      case (state_ff)
         bis_pkg::ST_IDLE: begin
            if (accept && req_kind && chan_ok) begin
               state_in = bis_pkg::ST_MAP_X;
            end
         end
         bis_pkg::ST_MAP_X: begin
            state_in = bis_pkg::ST_MAP_Y;
         end
         bis_pkg::ST_MAP_Y: begin
            state_in = bis_pkg::ST_CLAMP_Y;
         end
         bis_pkg::ST_CLAMP_Y: begin
            cnt_in   = 2'd0;
            state_in = bis_pkg::ST_FETCH;
         end
         bis_pkg::ST_FETCH: begin
            mem_re = 1'b1;
            v1_in  = 1'b1;
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               state_in = bis_pkg::ST_DRAIN;
            end
         end
         bis_pkg::ST_DRAIN: begin
            if (!v1_ff && !v2_ff) begin
               emit     = 1'b1;
               state_in = bis_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bis_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bis_pkg::ST_IDLE;
         cnt_ff       <= 2'd0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         v1_ff        <= v1_in;
         v2_ff        <= v1_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Shared position multiplier: x in the first map cycle, y in the second.
   assign mul_in = 32'(((state_ff == bis_pkg::ST_MAP_X) ? px_ff : py_ff))
                   * 32'(inv_scale_ff);

   // Clamp the integer part of the product and its successor to the edge.
   always_comb begin
      ipart    = mul_ff[31:16];
      ipart_p1 = 17'(ipart) + 17'd1;
      x0_in = (17'(ipart) > 17'(last_x)) ? last_x : bis_pkg::X_BITS'(ipart);
      x1_in = (ipart_p1 > 17'(last_x)) ? last_x : bis_pkg::X_BITS'(ipart_p1);
      y0_in = (17'(ipart) > 17'(last_y)) ? last_y : bis_pkg::Y_BITS'(ipart);
      y1_in = (ipart_p1 > 17'(last_y)) ? last_y : bis_pkg::Y_BITS'(ipart_p1);
   end

   // Neighbor address and its combined weight for the current read.
   // The combined weight reaches 2^32 when both fractions are zero.
   always_comb begin
      fetch_addr = bis_pkg::store_addr(cnt_ff[0] ? x1_ff : x0_ff,
                                       cnt_ff[1] ? y1_ff : y0_ff, chan_ff);
      wx = cnt_ff[0] ? bis_pkg::WEIGHT_BITS'(fx_ff)
                     : bis_pkg::WEIGHT_ONE - bis_pkg::WEIGHT_BITS'(fx_ff);
      wy = cnt_ff[1] ? bis_pkg::WEIGHT_BITS'(fy_ff)
                     : bis_pkg::WEIGHT_ONE - bis_pkg::WEIGHT_BITS'(fy_ff);
      wprod     = (2*bis_pkg::WEIGHT_BITS)'(wx) * (2*bis_pkg::WEIGHT_BITS)'(wy);
      weight_in = wprod;
   end

   // Multiply each fetched sample by its weight, then accumulate.
   always_comb begin
      rd_sample = bis_pkg::FIELD_BITS'(mem_rdata_ff);
      pfull     = (bis_pkg::ACC_BITS+1)'(rd_sample) * (bis_pkg::ACC_BITS+1)'(weight_ff);
      prod_in   = pfull[bis_pkg::ACC_BITS-1:0];
      if (state_ff == bis_pkg::ST_CLAMP_Y) begin
         acc_in = '0;
      end else if (v2_ff) begin
         acc_in = acc_ff + prod_ff;
      end else begin
         acc_in = acc_ff;
      end
      rounded = (bis_pkg::ACC_BITS+1)'(acc_ff) + ((bis_pkg::ACC_BITS+1)'(1) << 31);
   end

   // Response: an out-of-range channel answers at once, a blend after draining.
   always_comb begin
      rsp_valid_in  = emit || bad_req;
      rsp_status_in = bad_req;
      rsp_sample_in = bad_req ? '0 : rounded[47:32];
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         px_ff   <= req_pos_x;
         py_ff   <= req_pos_y;
         chan_ff <= req_chan;
      end
      mul_ff <= mul_in;
      if (state_ff == bis_pkg::ST_MAP_Y) begin
         fx_ff <= mul_ff[bis_pkg::FRAC_BITS-1:0];
         x0_ff <= x0_in;
         x1_ff <= x1_in;
      end
      if (state_ff == bis_pkg::ST_CLAMP_Y) begin
         fy_ff <= mul_ff[bis_pkg::FRAC_BITS-1:0];
         y0_ff <= y0_in;
         y1_ff <= y1_in;
      end
      weight_ff     <= weight_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Single-port sample store: writes only while idle, reads only while fetching.
   assign write_addr = bis_pkg::store_addr(bis_pkg::X_BITS'(req_pos_x),
                                           bis_pkg::Y_BITS'(req_pos_y), req_chan);
   assign mem_addr   = busy ? fetch_addr : write_addr;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_addr] <= bis_pkg::SAMPLE_BITS'(req_sample_in);
      end
      if (mem_re) begin
         mem_rdata_ff <= store_mem[mem_addr];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_status     = rsp_status_ff;

   // The store port is never written while a request is reading it.
   assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == bis_pkg::ST_IDLE && !mem_re))
      else $error("store written while a request is in flight");

   // An interpolated response only follows the drain of the pipeline.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_status_ff) |-> ($past(state_ff) == bis_pkg::ST_DRAIN))
      else $error("interpolated response outside the drain step");

   // An accepted in-range request starts the position mapping.
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_kind && chan_ok) |=> (state_ff == bis_pkg::ST_MAP_X))
      else $error("accepted request did not start mapping");

endmodule

@@ tb/bilinear_image_scaler_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_image_scaler_tb
// Self-checking testbench of the bilinear image scaler. It keeps a shadow copy
// of the source image and of the registers, predicts every response from
// them, and checks each response against the oldest prediction. Directed
// tests cover the field extremes, the size, channel and scale limits and the
// rounding of halves; a long random part then runs mixed write and request
// traffic over many register settings, with random gaps on the request side.
// ----------------------------------------------------------------------------
module bilinear_image_scaler_tb;

   // Transaction kinds and response status codes.
   localparam logic KIND_WRITE         = 1'b0;
   localparam logic KIND_REQUEST       = 1'b1;
   localparam logic STATUS_OK          = 1'b0;
   localparam logic STATUS_BAD_CHANNEL = 1'b1;

   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 12;
   localparam int DRAIN_CYCLES  = 20;
   localparam int TRAFFIC_ITEMS = 800;

   typedef struct {
      logic [bis_pkg::FIELD_BITS-1:0] sample;
      logic                           status;
   } scaled_sample_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            start = 1'b0;
   logic                            busy;
   logic                            req_kind = KIND_WRITE;
   logic [bis_pkg::POS_BITS-1:0]    req_pos_x = '0;
   logic [bis_pkg::POS_BITS-1:0]    req_pos_y = '0;
   logic [bis_pkg::CHAN_BITS-1:0]   req_chan = '0;
   logic [bis_pkg::FIELD_BITS-1:0]  req_sample_in = '0;
   logic                            rsp_valid;
   logic [bis_pkg::FIELD_BITS-1:0]  rsp_sample_out;
   logic                            rsp_status;
   logic                            csr_write_enable = 1'b0;
   logic [1:0]                      csr_index = '0;
   logic [bis_pkg::CSR_BITS-1:0]    csr_data = '0;

   // Shadow of the source image and of the registers.
   logic [bis_pkg::FIELD_BITS-1:0]  image_mem [0:bis_pkg::STORE_DEPTH-1];
   bit                              image_valid [0:bis_pkg::STORE_DEPTH-1];
   logic [bis_pkg::SIZE_BITS-1:0]   cfg_width = bis_pkg::RESET_WIDTH;
   logic [bis_pkg::SIZE_BITS-1:0]   cfg_height = bis_pkg::RESET_HEIGHT;
   logic [bis_pkg::COUNT_BITS-1:0]  cfg_channels = bis_pkg::RESET_CHANNELS;
   logic [bis_pkg::SCALE_BITS-1:0]  cfg_scale = bis_pkg::RESET_SCALE;

   scaled_sample_type      expected_samples [$];
   int                     error_count = 0;
   int                     stall_cycles = 0;
   int                     sent_items = 0;
   bit                     idle_enabled = 1'b1;

   bilinear_image_scaler uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_kind         (req_kind),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_chan         (req_chan),
      .req_sample_in    (req_sample_in),
      .rsp_valid        (rsp_valid),
      .rsp_sample_out   (rsp_sample_out),
      .rsp_status       (rsp_status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------

   function automatic int unsigned size_limit(input logic [bis_pkg::SIZE_BITS-1:0] size,
                                              input int unsigned max_size);
      if (size == 0) return 1;
      if (32'(size) > max_size) return max_size;
      return 32'(size);
   endfunction

   function automatic int unsigned active_channels();
      return (32'(cfg_channels) > bis_pkg::MAX_CHANNELS) ?
             bis_pkg::MAX_CHANNELS : 32'(cfg_channels);
   endfunction

   function automatic int unsigned sample_index(input int unsigned x, input int unsigned y,
                                                input logic [bis_pkg::CHAN_BITS-1:0] c);
      return (y * bis_pkg::MAX_WIDTH + x) * bis_pkg::MAX_CHANNELS + 32'(c);
   endfunction

   function automatic logic [63:0] stored(input int unsigned x, input int unsigned y,
                                          input logic [bis_pkg::CHAN_BITS-1:0] c);
      return 64'(image_mem[sample_index(x, y, c)]);
   endfunction

   // Maps one output coordinate to its two clamped source neighbors and the blend fraction.
   function automatic void map_axis(input logic [bis_pkg::POS_BITS-1:0] pos,
                                    input int unsigned last,
                                    output int unsigned lo, output int unsigned hi,
                                    output logic [bis_pkg::FRAC_BITS-1:0] frac);
      logic [63:0] scaled;
      int unsigned whole;
      scaled = 64'(pos) * 64'(cfg_scale);
      frac = scaled[bis_pkg::FRAC_BITS-1:0];
      whole = scaled[47:16];
      lo = (whole > last) ? last : whole;
      hi = (whole + 1 > last) ? last : whole + 1;
   endfunction

   function automatic scaled_sample_type interpolate_sample(
         input logic [bis_pkg::POS_BITS-1:0] px, input logic [bis_pkg::POS_BITS-1:0] py,
         input logic [bis_pkg::CHAN_BITS-1:0] c);
      scaled_sample_type res;
      int unsigned x0, x1, y0, y1;
      logic [bis_pkg::FRAC_BITS-1:0] fx, fy;
      logic [63:0] top, bottom, acc;
      res.sample = '0;
      res.status = STATUS_BAD_CHANNEL;
      if (32'(c) < active_channels()) begin
         map_axis(px, size_limit(cfg_width, bis_pkg::MAX_WIDTH) - 1, x0, x1, fx);
         map_axis(py, size_limit(cfg_height, bis_pkg::MAX_HEIGHT) - 1, y0, y1, fy);
         top = stored(x0, y0, c) * (64'd65536 - 64'(fx)) + stored(x1, y0, c) * 64'(fx);
         bottom = stored(x0, y1, c) * (64'd65536 - 64'(fx)) + stored(x1, y1, c) * 64'(fx);
         acc = top * (64'd65536 - 64'(fy)) + bottom * 64'(fy) + (64'd1 << 31);
         res.sample = acc[47:32];
         res.status = STATUS_OK;
      end
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------

   task automatic report_mismatch(input string what);
      error_count++;
      $display("MISMATCH at %0t ns: %s", $time, what);
   endtask

   // Every response pulse is compared with the oldest prediction.
   always @(posedge clock) begin
      scaled_sample_type want;
      if (!reset && rsp_valid) begin
         if (expected_samples.size() == 0) begin
            report_mismatch($sformatf("response %h/%0d with no request outstanding",
                                      rsp_sample_out, rsp_status));
         end else begin
            want = expected_samples.pop_front();
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status %b, expected %b", rsp_status, want.status));
            if (rsp_sample_out !== want.sample)
               report_mismatch($sformatf("sample %h, expected %h", rsp_sample_out, want.sample));
         end
      end
   end

   // The run is abandoned when no transaction moves for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || csr_write_enable) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("bilinear_image_scaler test failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Drives one transaction, waits until the block takes it and updates the shadow state.
   // Start is left high; the next caller either reuses it or lowers it at a falling edge.
   // Each cycle before the transaction is idle with a chance of about one in seven.
   task automatic send_item(input logic kind, input logic [bis_pkg::POS_BITS-1:0] px,
                            input logic [bis_pkg::POS_BITS-1:0] py,
                            input logic [bis_pkg::CHAN_BITS-1:0] c,
                            input logic [bis_pkg::FIELD_BITS-1:0] value);
      @(negedge clock);
      if (idle_enabled) begin
         while ($urandom_range(99) < 15) begin
            start = 1'b0;
            @(negedge clock);
         end
      end
      start = 1'b1;
      req_kind = kind;
      req_pos_x = px;
      req_pos_y = py;
      req_chan = c;
      req_sample_in = value;
      do @(posedge clock); while (busy);
      sent_items++;
      if (kind == KIND_REQUEST) begin
         expected_samples.push_back(interpolate_sample(px, py, c));
      end else if (32'(c) < active_channels() && 32'(px) < bis_pkg::MAX_WIDTH
                   && 32'(py) < bis_pkg::MAX_HEIGHT) begin
         image_mem[sample_index(32'(px), 32'(py), c)] = value;
         image_valid[sample_index(32'(px), 32'(py), c)] = 1'b1;
      end
   endtask

   // Writes random data to every neighbor of a request that has never been written.
   task automatic fill_neighbors(input logic [bis_pkg::POS_BITS-1:0] px,
                                 input logic [bis_pkg::POS_BITS-1:0] py,
                                 input logic [bis_pkg::CHAN_BITS-1:0] c);
      int unsigned xs [2];
      int unsigned ys [2];
      logic [bis_pkg::FRAC_BITS-1:0] fx, fy;
      map_axis(px, size_limit(cfg_width, bis_pkg::MAX_WIDTH) - 1, xs[0], xs[1], fx);
      map_axis(py, size_limit(cfg_height, bis_pkg::MAX_HEIGHT) - 1, ys[0], ys[1], fy);
      for (int j = 0; j < 2; j++) begin
         for (int i = 0; i < 2; i++) begin
            if (!image_valid[sample_index(xs[i], ys[j], c)])
               send_item(KIND_WRITE, bis_pkg::POS_BITS'(xs[i]), bis_pkg::POS_BITS'(ys[j]), c,
                         bis_pkg::FIELD_BITS'($urandom));
         end
      end
   endtask

   task automatic request_sample(input logic [bis_pkg::POS_BITS-1:0] px,
                                 input logic [bis_pkg::POS_BITS-1:0] py,
                                 input logic [bis_pkg::CHAN_BITS-1:0] c);
      if (32'(c) < active_channels()) fill_neighbors(px, py, c);
      send_item(KIND_REQUEST, px, py, c, bis_pkg::FIELD_BITS'($urandom));
   endtask

   // Register writes happen only once every response is in and the block has settled.
   task automatic set_register(input bis_pkg::csr_index_type idx,
                               input logic [bis_pkg::CSR_BITS-1:0] value);
      @(negedge clock);
      start = 1'b0;
      while (expected_samples.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index = idx;
      csr_data = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
      case (idx)
         bis_pkg::CSR_SRC_WIDTH:     cfg_width = value[bis_pkg::SIZE_BITS-1:0];
         bis_pkg::CSR_SRC_HEIGHT:    cfg_height = value[bis_pkg::SIZE_BITS-1:0];
         bis_pkg::CSR_CHANNEL_COUNT: cfg_channels = value[bis_pkg::COUNT_BITS-1:0];
         bis_pkg::CSR_INV_SCALE:     cfg_scale = value[bis_pkg::SCALE_BITS-1:0];
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset settings: extreme samples and positions, ignored writes, a bad channel.
   task automatic test_reset_extremes();
      send_item(KIND_WRITE, 12'd0, 12'd0, 2'd0, 16'h0000);
      send_item(KIND_WRITE, 12'd255, 12'd255, 2'd2, 16'hFFFF);
      send_item(KIND_WRITE, 12'hFFF, 12'd0, 2'd0, 16'h1234);
      send_item(KIND_WRITE, 12'd0, 12'hFFF, 2'd1, 16'h4321);
      send_item(KIND_WRITE, 12'd0, 12'd0, 2'd3, 16'hFFFF);
      request_sample(12'd0, 12'd0, 2'd0);
      request_sample(12'hFFF, 12'hFFF, 2'd2);
      request_sample(12'd255, 12'd255, 2'd2);
      request_sample(12'd0, 12'd0, 2'd3);
      request_sample(12'hAAA, 12'h555, 2'd1);
   endtask

   // Sizes of zero and above the maximum, channel counts of zero and above four.
   task automatic test_size_channel_limits();
      set_register(bis_pkg::CSR_SRC_WIDTH, 20'd0);
      set_register(bis_pkg::CSR_SRC_HEIGHT, 20'd0);
      request_sample(12'd100, 12'd200, 2'd1);
      set_register(bis_pkg::CSR_SRC_WIDTH, 20'd511);
      set_register(bis_pkg::CSR_SRC_HEIGHT, 20'd257);
      set_register(bis_pkg::CSR_CHANNEL_COUNT, 20'd7);
      request_sample(12'hFFF, 12'hFFF, 2'd3);
      request_sample(12'd300, 12'd17, 2'd3);
      set_register(bis_pkg::CSR_CHANNEL_COUNT, 20'd0);
      send_item(KIND_WRITE, 12'd1, 12'd1, 2'd0, 16'hBEEF);
      request_sample(12'd0, 12'd0, 2'd0);
   endtask

   // Zero scale maps everything to the corner; the largest scale runs off the edges.
   task automatic test_scale_extremes();
      set_register(bis_pkg::CSR_CHANNEL_COUNT, 20'd4);
      set_register(bis_pkg::CSR_SRC_WIDTH, 20'd16);
      set_register(bis_pkg::CSR_SRC_HEIGHT, 20'd16);
      set_register(bis_pkg::CSR_INV_SCALE, 20'd0);
      request_sample(12'hFFF, 12'hFFF, 2'd1);
      set_register(bis_pkg::CSR_INV_SCALE, 20'hFFFFF);
      request_sample(12'd1, 12'd1, 2'd0);
      request_sample(12'd3, 12'd0, 2'd2);
   endtask

   // Half scale on a 0/1 ramp gives exact halves, which must round up.
   task automatic test_half_rounding();
      set_register(bis_pkg::CSR_SRC_WIDTH, 20'd4);
      set_register(bis_pkg::CSR_SRC_HEIGHT, 20'd4);
      set_register(bis_pkg::CSR_INV_SCALE, 20'h08000);
      send_item(KIND_WRITE, 12'd0, 12'd0, 2'd0, 16'd0);
      send_item(KIND_WRITE, 12'd1, 12'd0, 2'd0, 16'd1);
      send_item(KIND_WRITE, 12'd0, 12'd1, 2'd0, 16'd0);
      send_item(KIND_WRITE, 12'd1, 12'd1, 2'd0, 16'd1);
      request_sample(12'd1, 12'd0, 2'd0);
      request_sample(12'd1, 12'd1, 2'd0);
      request_sample(12'd2, 12'd2, 2'd0);
   endtask

   // Picks a position that lands inside the image for the current size and scale.
   function automatic logic [bis_pkg::POS_BITS-1:0] interior_pos(input int unsigned size);
      logic [63:0] reach;
      if (cfg_scale == 0) return bis_pkg::POS_BITS'($urandom);
      reach = (64'(size) << 16) / 64'(cfg_scale);
      if (reach > 4095) reach = 4095;
      return bis_pkg::POS_BITS'($urandom_range(0, int'(reach)));
   endfunction

   function automatic logic [bis_pkg::SIZE_BITS-1:0] random_size();
      case ($urandom_range(5))
         0: return 9'd1;
         1: return 9'd2;
         2, 3: return bis_pkg::SIZE_BITS'($urandom_range(2, 16));
         4: return 9'd256;
         default: return bis_pkg::SIZE_BITS'($urandom_range(0, 511));
      endcase
   endfunction

   function automatic logic [bis_pkg::SCALE_BITS-1:0] random_scale();
      case ($urandom_range(6))
         0: return 20'h10000;
         1, 2: return bis_pkg::SCALE_BITS'($urandom_range(20'h01000, 20'h30000));
         3: return bis_pkg::SCALE_BITS'($urandom_range(1, 20'hFFFFF));
         4: return 20'hFFFFF;
         5: return 20'h00000;
         default: return bis_pkg::SCALE_BITS'($urandom_range(20'h04000, 20'h10000));
      endcase
   endfunction

   // Random settings per phase; mostly well-formed requests and image writes, some noise.
   // The run stops once the total number of transactions reaches the item budget.
   task automatic test_random_traffic();
      int phase;
      int phase_items;
      int unsigned w_eff, h_eff, nch;
      int pick;
      phase = 0;
      while (sent_items < TRAFFIC_ITEMS) begin
         set_register(bis_pkg::CSR_SRC_WIDTH,
                      (bis_pkg::CSR_BITS'($urandom) << bis_pkg::SIZE_BITS)
                      | 20'(random_size()));
         set_register(bis_pkg::CSR_SRC_HEIGHT,
                      (bis_pkg::CSR_BITS'($urandom) << bis_pkg::SIZE_BITS)
                      | 20'(random_size()));
         set_register(bis_pkg::CSR_CHANNEL_COUNT, ($urandom_range(3) == 0) ?
                      bis_pkg::CSR_BITS'($urandom) : bis_pkg::CSR_BITS'($urandom_range(1, 4)));
         set_register(bis_pkg::CSR_INV_SCALE, random_scale());
         // One phase runs back to back without any gaps.
         idle_enabled = (phase != 2);
         w_eff = size_limit(cfg_width, bis_pkg::MAX_WIDTH);
         h_eff = size_limit(cfg_height, bis_pkg::MAX_HEIGHT);
         nch = active_channels();
         phase_items = $urandom_range(60, 120);
         for (int n = 0; n < phase_items && sent_items < TRAFFIC_ITEMS; n++) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
               request_sample(interior_pos(w_eff), interior_pos(h_eff),
                              (nch == 0) ? bis_pkg::CHAN_BITS'($urandom) :
                              bis_pkg::CHAN_BITS'($urandom_range(0, nch - 1)));
            end else if (pick < 55) begin
               request_sample(bis_pkg::POS_BITS'($urandom), bis_pkg::POS_BITS'($urandom),
                              bis_pkg::CHAN_BITS'($urandom));
            end else if (pick < 85 && nch != 0) begin
               send_item(KIND_WRITE, bis_pkg::POS_BITS'($urandom_range(0, w_eff - 1)),
                         bis_pkg::POS_BITS'($urandom_range(0, h_eff - 1)),
                         bis_pkg::CHAN_BITS'($urandom_range(0, nch - 1)),
                         bis_pkg::FIELD_BITS'($urandom));
            end else begin
               send_item(KIND_WRITE, bis_pkg::POS_BITS'($urandom),
                         bis_pkg::POS_BITS'($urandom), bis_pkg::CHAN_BITS'($urandom),
                         bis_pkg::FIELD_BITS'($urandom));
            end
         end
         phase++;
      end
      idle_enabled = 1'b1;
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_extremes();
      test_size_channel_limits();
      test_scale_extremes();
      test_half_rounding();
      test_random_traffic();

      // Let the last responses come back, then give the block time for stray ones.
      @(negedge clock);
      start = 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_samples.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", expected_samples.size()));

      if (error_count == 0) begin
         $display("bilinear_image_scaler test passed");
      end else begin
         $display("bilinear_image_scaler test failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/bis_pkg.sv
hdl/bilinear_image_scaler.sv
tb/bilinear_image_scaler_tb.sv
